// ===== sv/pwq_pkg.sv =====
// ----------------------------------------------------------------------------
// Priority wait queue package
// Shared sizes, codes, entry layout and bus payload layouts.
// ----------------------------------------------------------------------------
package pwq_pkg;

   // Queue sizing
   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_RESULTS = 16;
   localparam int WAKE_LIMIT  = (MAX_RESULTS < QUEUE_DEPTH) ? MAX_RESULTS : QUEUE_DEPTH;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Operation codes carried on the request tuser
   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_WAKE_ONE = 2'd2,
      OP_WAKE_ALL = 2'd3
   } op_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_INS_HEAD,
      S_RM_RD,
      S_RM_CMP,
      S_SH_RD,
      S_SH_WR,
      S_EMIT,
      S_WA_FIRST,
      S_WA_CAP,
      S_WA_RD,
      S_WA_EMIT
   } state_type;

   // One stored waiter
   typedef struct packed {
      logic [7:0] id;
      logic [7:0] prio;
   } entry_type;

   // Flags returned by the shared compare unit
   typedef struct packed {
      logic             prio_le;
      logic             id_eq;
      logic             at_limit;
      logic [CNT_W-1:0] idx_inc;
   } cmp_type;

   // Request tdata layout, lowest bit last
   typedef struct packed {
      logic [6:0] pad;
      logic       holds_resource;
      logic [7:0] priority_req;
      logic [7:0] waiter_id;
   } req_data_type;

   // Result tdata layout, lowest bit last
   typedef struct packed {
      logic [5:0] pad;
      logic [4:0] waiter_count;
      logic       bridges_possible;
      logic [7:0] head_prio;
      logic       top_valid;
      logic       woken_valid;
      logic [7:0] woken_id;
      logic [1:0] status;
   } rsp_data_type;

endpackage

// ===== sv/pwq_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// Priority wait queue compare unit
// The one compare and increment unit that every scan and shift step shares.
// ----------------------------------------------------------------------------
module pwq_cmp_unit (
   input  pwq_pkg::entry_type             rd_entry,
   input  logic [7:0]                     key_id,
   input  logic [7:0]                     key_prio,
   input  logic [pwq_pkg::CNT_W-1:0]      idx,
   input  logic [pwq_pkg::CNT_W-1:0]      limit,
   output pwq_pkg::cmp_type               cmp
);

   logic [pwq_pkg::CNT_W-1:0] idx_next;

   // Step the scan index and test it against the end of the scan.
   assign idx_next = idx + pwq_pkg::CNT_W'(1);

   // Priority order keeps equal priorities first-in, so less or equal stops the scan.
   always_comb begin
      cmp.prio_le  = (rd_entry.prio <= key_prio);
      cmp.id_eq    = (rd_entry.id == key_id);
      cmp.at_limit = (idx_next == limit);
      cmp.idx_inc  = idx_next;
   end

endmodule

// ===== sv/priority_wait_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Priority wait queue
// Waiter queue sorted by priority with first-in order among equals.
// ----------------------------------------------------------------------------
// The queue lives in a single-port-write, single-port-read store with a
// registered read, and one compare unit under a small sequencer walks it; the
// block accepts a transaction only when the sequencer is idle. An insert
// walks from the tail and moves each entry with a worse priority down; a
// remove compares from the head and moves every entry behind the one taken
// out up; a wake-one takes the head and moves the rest of the queue up through
// the store; a wake-all releases waiters one result at a time and then moves
// any left up. Refused or empty requests go straight to their result. A result
// that waits on the response side holds the sequencer. The output register
// lets the next request be taken while the last result still waits on the
// response side.
// ----------------------------------------------------------------------------
module priority_wait_queue_unit (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // waiter_id[7:0], priority_req[15:8], holds_resource[16]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // status[1:0], woken_id[9:2], woken_valid[10],
                                    // top_valid[11], head_prio[19:12],
                                    // bridges_possible[20], waiter_count[25:21]
   output logic        rsp_tlast
);

   localparam int CW = pwq_pkg::CNT_W;
   localparam int IW = pwq_pkg::IDX_W;

   // Sequencer and request registers
   pwq_pkg::state_type  state_ff, state_in;
   pwq_pkg::op_type     op_ff, op_in;
   logic [7:0]          id_ff, id_in;
   logic [7:0]          pr_ff, pr_in;
   logic                holds_ff, holds_in;
   pwq_pkg::status_type status_ff, status_in;

   // Scan and shift pointers
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       dst_ff, dst_in;
   logic [CW-1:0]       gap_ff, gap_in;
   logic [CW-1:0]       ktot_ff, ktot_in;
   logic                silent_ff, silent_in;
   logic [7:0]          woken_id_ff, woken_id_in;
   logic                woken_v_ff, woken_v_in;

   // Queue status
   logic [CW-1:0]       count_ff, count_in;
   logic                bridge_ff, bridge_in;
   logic [7:0]          head_ff, head_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   pwq_pkg::rsp_data_type rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   // Entry store
   pwq_pkg::entry_type  entry_mem_ff [pwq_pkg::QUEUE_DEPTH];
   pwq_pkg::entry_type  mem_rd_ff;
   logic [IW-1:0]       rd_addr;
   logic                mem_we;
   logic [IW-1:0]       mem_waddr;
   pwq_pkg::entry_type  mem_wdata;

   // Shared unit and helpers
   pwq_pkg::cmp_type    cmp;
   logic [CW-1:0]       cmp_limit;
   pwq_pkg::req_data_type req_data;
   logic                req_fire;
   logic                slot_free;
   logic                emit;
   pwq_pkg::rsp_data_type emit_data;
   logic                emit_last;
   logic                rm_match;
   logic                shift_done;
   logic [CW-1:0]       count_less_gap;
   logic [CW-1:0]       wa_remain;
   logic                full;

   assign req_data       = pwq_pkg::req_data_type'(req_tdata);
   assign req_fire       = req_tvalid && req_tready;
   assign req_tready     = (state_ff == pwq_pkg::S_IDLE) && !reset;
   assign slot_free      = !rsp_valid_ff || rsp_tready;
   assign full           = (count_ff == CW'(pwq_pkg::QUEUE_DEPTH));
   assign shift_done     = (idx_ff >= count_ff);
   assign count_less_gap = count_ff - gap_ff;
   assign wa_remain      = count_ff - cmp.idx_inc;
   assign rm_match       = (op_ff == pwq_pkg::OP_WAKE_ONE) || cmp.id_eq;

   // Wake-all counts against the number it may release, all else against the fill.
   always_comb begin
      case (state_ff)
         pwq_pkg::S_WA_FIRST, pwq_pkg::S_WA_CAP,
         pwq_pkg::S_WA_RD, pwq_pkg::S_WA_EMIT: cmp_limit = ktot_ff;
         default:                              cmp_limit = count_ff;
      endcase
   end

   pwq_cmp_unit u_cmp (
      .rd_entry (mem_rd_ff),
      .key_id   (id_ff),
      .key_prio (pr_ff),
      .idx      (idx_ff),
      .limit    (cmp_limit),
      .cmp      (cmp)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pwq_pkg::S_IDLE: begin
            if (req_fire) begin
               case (pwq_pkg::op_type'(req_tuser))
                  pwq_pkg::OP_INSERT: begin
                     if (full) begin
                        state_in = pwq_pkg::S_EMIT;
                     end else if (count_ff == '0) begin
                        state_in = pwq_pkg::S_INS_HEAD;
                     end else begin
                        state_in = pwq_pkg::S_INS_RD;
                     end
                  end
                  pwq_pkg::OP_REMOVE, pwq_pkg::OP_WAKE_ONE: begin
                     state_in = (count_ff == '0) ? pwq_pkg::S_EMIT : pwq_pkg::S_RM_RD;
                  end
                  pwq_pkg::OP_WAKE_ALL: begin
                     state_in = (count_ff == '0) ? pwq_pkg::S_EMIT : pwq_pkg::S_WA_FIRST;
                  end
                  default: state_in = pwq_pkg::S_IDLE;
               endcase
            end
         end
         pwq_pkg::S_INS_RD: state_in = pwq_pkg::S_INS_CMP;
         pwq_pkg::S_INS_CMP: begin
            if (cmp.prio_le) begin
               state_in = pwq_pkg::S_EMIT;
            end else if (idx_ff == '0) begin
               state_in = pwq_pkg::S_INS_HEAD;
            end
         end
         pwq_pkg::S_INS_HEAD: state_in = pwq_pkg::S_EMIT;
         pwq_pkg::S_RM_RD:    state_in = pwq_pkg::S_RM_CMP;
         pwq_pkg::S_RM_CMP: begin
            if (rm_match) begin
               state_in = pwq_pkg::S_SH_RD;
            end else if (cmp.at_limit) begin
               state_in = pwq_pkg::S_EMIT;
            end
         end
         pwq_pkg::S_SH_RD: begin
            if (shift_done) begin
               state_in = silent_ff ? pwq_pkg::S_IDLE : pwq_pkg::S_EMIT;
            end else begin
               state_in = pwq_pkg::S_SH_WR;
            end
         end
         pwq_pkg::S_SH_WR: state_in = pwq_pkg::S_SH_RD;
         pwq_pkg::S_EMIT: begin
            if (slot_free) begin
               state_in = pwq_pkg::S_IDLE;
            end
         end
         pwq_pkg::S_WA_FIRST: state_in = pwq_pkg::S_WA_CAP;
         pwq_pkg::S_WA_CAP:   state_in = pwq_pkg::S_WA_EMIT;
         pwq_pkg::S_WA_RD:    state_in = pwq_pkg::S_WA_EMIT;
         pwq_pkg::S_WA_EMIT: begin
            if (slot_free) begin
               if (!cmp.at_limit) begin
                  state_in = pwq_pkg::S_WA_RD;
               end else if (wa_remain == '0) begin
                  state_in = pwq_pkg::S_IDLE;
               end else begin
                  state_in = pwq_pkg::S_SH_RD;
               end
            end
         end
         default: state_in = pwq_pkg::S_IDLE;
      endcase
   end

   // Datapath, store access and result assembly
   always_comb begin
      op_in       = op_ff;
      id_in       = id_ff;
      pr_in       = pr_ff;
      holds_in    = holds_ff;
      status_in   = status_ff;
      idx_in      = idx_ff;
      dst_in      = dst_ff;
      gap_in      = gap_ff;
      ktot_in     = ktot_ff;
      silent_in   = silent_ff;
      woken_id_in = woken_id_ff;
      woken_v_in  = woken_v_ff;
      count_in    = count_ff;
      bridge_in   = bridge_ff;
      head_in     = head_ff;
      rd_addr     = idx_ff[IW-1:0];
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = '0;
      emit        = 1'b0;
      emit_data   = '0;
      emit_last   = 1'b0;

      case (state_ff)
         // Capture the request and pick the starting point of the walk.
         pwq_pkg::S_IDLE: begin
            if (req_fire) begin
               op_in       = pwq_pkg::op_type'(req_tuser);
               id_in       = req_data.waiter_id;
               pr_in       = req_data.priority_req;
               holds_in    = req_data.holds_resource;
               woken_id_in = '0;
               woken_v_in  = 1'b0;
               silent_in   = 1'b0;
               gap_in      = CW'(1);
               dst_in      = '0;
               ktot_in     = (count_ff > CW'(pwq_pkg::WAKE_LIMIT)) ?
                             CW'(pwq_pkg::WAKE_LIMIT) : count_ff;
               status_in   = pwq_pkg::ST_DONE;
               idx_in      = '0;
               case (pwq_pkg::op_type'(req_tuser))
                  pwq_pkg::OP_INSERT: begin
                     idx_in = count_ff - CW'(1);
                     if (full) begin
                        status_in = pwq_pkg::ST_FULL;
                     end
                  end
                  pwq_pkg::OP_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = pwq_pkg::ST_NOT_FOUND;
                     end
                  end
                  pwq_pkg::OP_WAKE_ONE, pwq_pkg::OP_WAKE_ALL: begin
                     if (count_ff == '0) begin
                        status_in = pwq_pkg::ST_EMPTY;
                     end
                  end
                  default: status_in = pwq_pkg::ST_DONE;
               endcase
            end
         end

         pwq_pkg::S_INS_RD: rd_addr = idx_ff[IW-1:0];

         // Insert walks from the tail, moving worse entries down by one.
         pwq_pkg::S_INS_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = cmp.idx_inc[IW-1:0];
            if (cmp.prio_le) begin
               mem_wdata = '{id: id_ff, prio: pr_ff};
               count_in  = count_ff + CW'(1);
               bridge_in = bridge_ff | holds_ff;
            end else begin
               mem_wdata = mem_rd_ff;
               if (idx_ff != '0) begin
                  idx_in  = idx_ff - CW'(1);
                  rd_addr = idx_in[IW-1:0];
               end
            end
         end

         pwq_pkg::S_INS_HEAD: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '{id: id_ff, prio: pr_ff};
            head_in   = pr_ff;
            count_in  = count_ff + CW'(1);
            bridge_in = bridge_ff | holds_ff;
         end

         pwq_pkg::S_RM_RD: rd_addr = idx_ff[IW-1:0];

         // Remove scans from the head; wake-one takes the head at once.
         pwq_pkg::S_RM_CMP: begin
            if (rm_match) begin
               if (op_ff == pwq_pkg::OP_WAKE_ONE) begin
                  woken_id_in = mem_rd_ff.id;
                  woken_v_in  = 1'b1;
               end
               dst_in = idx_ff;
               idx_in = cmp.idx_inc;
            end else if (cmp.at_limit) begin
               status_in = pwq_pkg::ST_NOT_FOUND;
            end else begin
               idx_in  = cmp.idx_inc;
               rd_addr = cmp.idx_inc[IW-1:0];
            end
         end

         // Close the gap: entries from the source pointer move up by the gap.
         pwq_pkg::S_SH_RD: begin
            if (shift_done) begin
               count_in = count_less_gap;
               if (count_less_gap == '0) begin
                  bridge_in = 1'b0;
               end
            end else begin
               rd_addr = idx_ff[IW-1:0];
            end
         end

         pwq_pkg::S_SH_WR: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff[IW-1:0];
            mem_wdata = mem_rd_ff;
            if (dst_ff == '0) begin
               head_in = mem_rd_ff.prio;
            end
            idx_in = cmp.idx_inc;
            dst_in = dst_ff + CW'(1);
         end

         // Single result from the updated queue status.
         pwq_pkg::S_EMIT: begin
            emit                       = slot_free;
            emit_last                  = 1'b1;
            emit_data.status           = status_ff;
            emit_data.woken_id         = woken_id_ff;
            emit_data.woken_valid      = woken_v_ff;
            emit_data.top_valid        = (count_ff != '0);
            emit_data.head_prio        = (count_ff != '0) ? head_ff : 8'd0;
            emit_data.bridges_possible = bridge_ff;
            emit_data.waiter_count     = 5'(count_ff);
         end

         pwq_pkg::S_WA_FIRST: rd_addr = '0;

         pwq_pkg::S_WA_CAP: begin
            woken_id_in = mem_rd_ff.id;
            rd_addr     = cmp.idx_inc[IW-1:0];
         end

         pwq_pkg::S_WA_RD: rd_addr = cmp.idx_inc[IW-1:0];

         // Wake-all: each result pops one waiter; the next entry gives the new head.
         pwq_pkg::S_WA_EMIT: begin
            rd_addr                    = cmp.idx_inc[IW-1:0];
            emit                       = slot_free;
            emit_last                  = cmp.at_limit;
            emit_data.status           = pwq_pkg::ST_DONE;
            emit_data.woken_id         = woken_id_ff;
            emit_data.woken_valid      = 1'b1;
            emit_data.top_valid        = (wa_remain != '0);
            emit_data.head_prio        = (wa_remain != '0) ? mem_rd_ff.prio : 8'd0;
            emit_data.bridges_possible = (wa_remain != '0) ? bridge_ff : 1'b0;
            emit_data.waiter_count     = 5'(wa_remain);
            if (slot_free) begin
               woken_id_in = mem_rd_ff.id;
               idx_in      = cmp.idx_inc;
               if (cmp.at_limit) begin
                  if (wa_remain == '0) begin
                     count_in  = '0;
                     bridge_in = 1'b0;
                  end else begin
                     idx_in    = ktot_ff;
                     dst_in    = '0;
                     gap_in    = ktot_ff;
                     silent_in = 1'b1;
                  end
               end
            end
         end

         default: rd_addr = idx_ff[IW-1:0];
      endcase
   end

   // Output register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Entry store with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= entry_mem_ff[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pwq_pkg::S_IDLE;
         count_ff     <= '0;
         bridge_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bridge_ff    <= bridge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      pr_ff       <= pr_in;
      holds_ff    <= holds_in;
      status_ff   <= status_in;
      idx_ff      <= idx_in;
      dst_ff      <= dst_in;
      gap_ff      <= gap_in;
      ktot_ff     <= ktot_in;
      silent_ff   <= silent_in;
      woken_id_ff <= woken_id_in;
      woken_v_ff  <= woken_v_in;
      head_ff     <= head_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
